[src/mcsw_pkg.sv]
// ----------------------------------------------------------------------------
// mcsw_pkg
// Types, register indexes and helpers shared by the stall watchdog files.
// ----------------------------------------------------------------------------
package mcsw_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int CHAN_W       = 4;
    localparam int CHAN_CODES   = 1 << CHAN_W;
    localparam int VALUE_W      = 64;
    localparam int TIME_W       = 48;
    localparam int COUNT_W      = 32;
    localparam int MAX_W        = 17;
    localparam int INTERVAL_W   = 32;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_STALL_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL_US = 1'd1;

    localparam logic [MAX_W-1:0] MAX_STALL_RESET = {MAX_W{1'b1}};

    typedef struct packed {
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] sample_value;
        logic [TIME_W-1:0]  round_start_us;
        logic [TIME_W-1:0]  now_us;
    } sample_t;

    typedef struct packed {
        logic               stalled;
        logic               report;
        logic               fatal;
        logic [COUNT_W-1:0] consecutive_stalls;
        logic [COUNT_W-1:0] total_stalls;
        logic [COUNT_W-1:0] channel_polls;
        logic [TIME_W-1:0]  unchanged_age_us;
        logic [COUNT_W-1:0] all_stalls;
        logic [COUNT_W-1:0] all_polls;
    } result_t;

    typedef struct packed {
        logic [VALUE_W-1:0] last_sample;
        logic [COUNT_W-1:0] poll_count;
        logic [COUNT_W-1:0] run_stalls;
        logic [COUNT_W-1:0] sum_stalls;
        logic [TIME_W-1:0]  change_time;
        logic [TIME_W-1:0]  report_time;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    endfunction

endpackage

[src/mcsw_ram.sv]
// ----------------------------------------------------------------------------
// mcsw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mcsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/multi_channel_stall_watchdog.sv]
// ----------------------------------------------------------------------------
// multi_channel_stall_watchdog
// Per-channel stall detection on polled progress counters.
// ----------------------------------------------------------------------------
// Each sample word carries a channel number, the watched counter value, the
// poll-round start time and the current time. The block answers every sample
// with one result word holding the stall, report and fatal flags and the
// channel and global counters after this poll.
// Per-channel state sits in one RAM word per channel. A sample is taken in
// the idle cycle, which also issues the RAM read; the update cycle then
// updates the word, writes it back and loads the result register. Because of
// this read-modify-write of the RAM, a new sample is only taken after the
// write-back. While a result is held by a stall on the result channel, the
// next sample is taken and waits in the update cycle until the result
// register frees up.
// After reset all channel entries read as zero through per-channel valid
// flags, so no clearing pass is needed. Configuration writes are taken on
// any cycle with cfg_we high.
// ----------------------------------------------------------------------------
module multi_channel_stall_watchdog #(
    parameter int CHANNELS = mcsw_pkg::CHANNELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  mcsw_pkg::sample_t                    sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output mcsw_pkg::result_t                    result,
    input  logic                                 cfg_we,
    input  logic [mcsw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mcsw_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import mcsw_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    state_t              state_reg, state_next;
    sample_t             item_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                hit_reg;
    logic [CHANNELS-1:0] valid_bits_reg;
    logic [MAX_W-1:0]    max_stall_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [COUNT_W-1:0]  gstalls_reg, gstalls_next;
    logic [COUNT_W-1:0]  gpolls_reg, gpolls_next;
    logic                fatal_reg, fatal_next;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    logic [IDX_W-1:0]    chan_map [CHAN_CODES];
    logic [IDX_W-1:0]    in_idx;
    logic                accept;
    logic                mem_we;
    logic                mem_re;
    logic                proceed;
    logic [ENTRY_W-1:0]  rdata;
    entry_t              ent;
    entry_t              ent_new;

    logic                polled_before;
    logic                stalled;
    logic [COUNT_W-1:0]  poll_new;
    logic [COUNT_W-1:0]  run_inc;
    logic [COUNT_W-1:0]  sum_inc;
    logic                fatal_now;
    logic [TIME_W:0]     limit_sum;
    logic                suppressed;
    logic                report;
    logic                report_upd;
    logic [TIME_W-1:0]   age;

    for (genvar g = 0; g < CHAN_CODES; g++)
    begin : g_chan_map
        assign chan_map[g] = IDX_W'(g % CHANNELS);
    end

    assign in_idx  = chan_map[sample.channel];
    assign accept  = sample_valid && !sample_stall;
    assign proceed = !result_valid_reg || !result_stall;

    mcsw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS),
        .AW    (IDX_W)
    ) u_state_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (ent_new),
        .re    (mem_re),
        .raddr (in_idx),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (proceed)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sample_stall = 1'b1;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                mem_re       = sample_valid;
            end
            ST_UPDATE:
            begin
                mem_we = proceed;
            end
            default:
            begin
                sample_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        ent           = hit_reg ? entry_t'(rdata) : '0;
        poll_new      = sat_inc(ent.poll_count);
        polled_before = ent.poll_count != '0;
        stalled       = polled_before && (item_reg.sample_value == ent.last_sample);
        run_inc       = sat_inc(ent.run_stalls);
        sum_inc       = sat_inc(ent.sum_stalls);
        fatal_now     = stalled && !max_stall_reg[MAX_W-1]
                        && (run_inc > COUNT_W'(max_stall_reg[MAX_W-2:0]));
        limit_sum     = {1'b0, ent.report_time} + (TIME_W + 1)'(interval_reg);
        suppressed    = (sum_inc > COUNT_W'(1)) && ({1'b0, item_reg.now_us} <= limit_sum);
        report        = stalled && (fatal_now || !suppressed);
        report_upd    = stalled && !fatal_now && !suppressed;

        ent_new.last_sample = item_reg.sample_value;
        ent_new.poll_count  = poll_new;
        ent_new.run_stalls  = stalled ? run_inc : '0;
        ent_new.sum_stalls  = stalled ? sum_inc : ent.sum_stalls;
        ent_new.change_time = stalled ? ent.change_time : item_reg.round_start_us;
        ent_new.report_time = report_upd ? item_reg.now_us : ent.report_time;

        age = (item_reg.now_us >= ent_new.change_time)
              ? item_reg.now_us - ent_new.change_time : '0;

        gpolls_next  = sat_inc(gpolls_reg);
        gstalls_next = stalled ? sat_inc(gstalls_reg) : gstalls_reg;
        fatal_next   = fatal_reg || fatal_now;

        result_next.stalled            = stalled;
        result_next.report             = report;
        result_next.fatal              = fatal_next;
        result_next.consecutive_stalls = ent_new.run_stalls;
        result_next.total_stalls       = ent_new.sum_stalls;
        result_next.channel_polls      = poll_new;
        result_next.unchanged_age_us   = age;
        result_next.all_stalls         = gstalls_next;
        result_next.all_polls          = gpolls_next;

        priority if (mem_we)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            valid_bits_reg   <= '0;
            hit_reg          <= 1'b0;
            max_stall_reg    <= MAX_STALL_RESET;
            interval_reg     <= '0;
            gstalls_reg      <= '0;
            gpolls_reg       <= '0;
            fatal_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                hit_reg <= valid_bits_reg[in_idx];
            end
            if (mem_we)
            begin
                valid_bits_reg[idx_reg] <= 1'b1;
                gstalls_reg             <= gstalls_next;
                gpolls_reg              <= gpolls_next;
                fatal_reg               <= fatal_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAX_STALL_COUNT:    max_stall_reg <= cfg_data[MAX_W-1:0];
                    REG_REPORT_INTERVAL_US: interval_reg  <= cfg_data[INTERVAL_W-1:0];
                    default:                interval_reg  <= interval_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= sample;
            idx_reg  <= in_idx;
        end
        if (mem_we)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_fatal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fatal_reg |=> fatal_reg)
        else $error("fatal flag cleared after being latched");

    a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_UPDATE))
        else $error("accepted sample did not enter the update cycle");

    a_report_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (!result_reg.report || result_reg.stalled))
        else $error("report flagged without a stall");

    a_run_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.consecutive_stalls <= result_reg.total_stalls))
        else $error("consecutive stalls exceed total stalls");

endmodule
